// ===== sv/edge_slot_assigner_assert.svh =====
// Assertion macros for the edge slot assigner checks.
`ifndef EDGE_SLOT_ASSIGNER_ASSERT_SVH
`define EDGE_SLOT_ASSIGNER_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ESA_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("edge_slot_assigner: assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define ESA_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("edge_slot_assigner: assertion failed");

`endif

// ===== sv/esa_pkg.sv =====
package esa_pkg;

  localparam int unsigned MAX_NODES = 1024;
  localparam int unsigned MAX_SLOTS = 64;
  localparam int unsigned MAX_EDGES = 65536;

  localparam int unsigned CENTER_W   = 10;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned EDGE_W     = 16;
  localparam int unsigned ADDR_W     = 16;
  localparam int unsigned NODES_W    = 11;
  localparam int unsigned SLOTS_W    = 7;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CNT_W      = 7;
  localparam int unsigned ECNT_W     = 17;
  localparam int unsigned EPOCH_W    = 8;
  localparam int unsigned PROD_W     = CENTER_W + SLOTS_W;
  localparam int unsigned NODE_IDX_W = $clog2(MAX_NODES);
  localparam int unsigned FILL_W     = EPOCH_W + CNT_W;
  localparam int unsigned SLOT_CAP   = (MAX_SLOTS < 64) ? MAX_SLOTS : 64;

  localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_EDGES = 2'd3
  } status_e;

  typedef enum logic {
    CFG_NODES = 1'b0,
    CFG_SLOTS = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [NODES_W-1:0] node_lim;
    logic [SLOTS_W-1:0] slot_lim;
  } cfg_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center;
    logic                first;
    logic                range_bad;
    logic [EPOCH_W-1:0]  epoch;
    logic [ADDR_W-1:0]   base;
  } job_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [CNT_W-1:0]   count;
  } fill_t;

  typedef struct packed {
    logic                  active;
    logic [NODE_IDX_W-1:0] addr;
  } clr_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_number;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] table_address;
    status_e           status;
  } result_t;

endpackage

// ===== sv/esa_ram.sv =====
module esa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// ===== sv/esa_front.sv =====
module esa_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic [esa_pkg::CENTER_W-1:0] center_i,
  input  logic                         first_edge_i,
  input  esa_pkg::cfg_t                cfg_i,
  input  logic                         back_idle_i,
  output logic                         job_valid_o,
  output esa_pkg::job_t                job_o,
  input  logic                         job_ready_i,
  output esa_pkg::clr_t                clr_o
);
  import esa_pkg::*;

  typedef enum logic [2:0] {
    FS_CLEAR = 3'b001,
    FS_RUN   = 3'b010,
    FS_DRAIN = 3'b100
  } fstate_e;

  fstate_e               state_q, state_d;
  logic [NODE_IDX_W-1:0] ptr_q, ptr_d;
  logic [EPOCH_W-1:0]    epoch_q, epoch_d;
  logic                  clean_q, clean_d;

  job_t        q_mem_q [2];
  logic        q_wr_q, q_rd_q;
  logic [1:0]  q_cnt_q;
  logic        q_full, q_empty, q_pop;

  logic         wrap_hold, accept;
  logic [PROD_W-1:0] prod;
  job_t         job_new;

  assign q_full  = (q_cnt_q == 2'd2);
  assign q_empty = (q_cnt_q == 2'd0);

  // a new batch at the last epoch needs a clearing pass before it enters, unless the counters are already clean
  assign wrap_hold = first_edge_i && (epoch_q == EPOCH_LAST) && !clean_q;
  assign full_o    = q_full || (state_q != FS_RUN) || wrap_hold;
  assign accept    = push_i && !full_o;

  assign job_valid_o = !q_empty;
  assign job_o       = q_mem_q[q_rd_q];
  assign q_pop       = job_valid_o && job_ready_i;

  assign prod = PROD_W'(center_i) * PROD_W'(cfg_i.slot_lim);

  always_comb begin
    job_new.center    = center_i;
    job_new.first     = first_edge_i;
    job_new.range_bad = (NODES_W'(center_i) >= cfg_i.node_lim);
    job_new.epoch     = first_edge_i ? epoch_q + EPOCH_W'(1) : epoch_q;
    job_new.base      = prod[ADDR_W-1:0];
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    epoch_d = epoch_q;
    clean_d = clean_q;
    unique case (state_q)
      FS_CLEAR: begin
        ptr_d = ptr_q + NODE_IDX_W'(1);
        if (ptr_q == NODE_IDX_W'(MAX_NODES - 1)) begin
          ptr_d   = '0;
          state_d = FS_RUN;
          clean_d = 1'b1;
        end
      end
      FS_RUN: begin
        if (push_i && wrap_hold) begin
          state_d = FS_DRAIN;
        end
        if (accept) begin
          clean_d = 1'b0;
        end
        if (accept && first_edge_i) begin
          epoch_d = epoch_q + EPOCH_W'(1);
        end
      end
      FS_DRAIN: begin
        if (q_empty && back_idle_i) begin
          state_d = FS_CLEAR;
          ptr_d   = '0;
        end
      end
      default: begin
        state_d = FS_CLEAR;
        ptr_d   = '0;
      end
    endcase
  end

  always_comb begin
    clr_o.active = (state_q == FS_CLEAR);
    clr_o.addr   = ptr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FS_CLEAR;
      ptr_q   <= '0;
      epoch_q <= EPOCH_LAST;
      clean_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
      epoch_q <= epoch_d;
      clean_q <= clean_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wr_q  <= 1'b0;
      q_rd_q  <= 1'b0;
      q_cnt_q <= 2'd0;
    end else begin
      if (accept) begin
        q_wr_q <= ~q_wr_q;
      end
      if (q_pop) begin
        q_rd_q <= ~q_rd_q;
      end
      case ({accept, q_pop})
        2'b10:   q_cnt_q <= q_cnt_q + 2'd1;
        2'b01:   q_cnt_q <= q_cnt_q - 2'd1;
        default: q_cnt_q <= q_cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      q_mem_q[q_wr_q] <= job_new;
    end
  end

endmodule

// ===== sv/esa_back.sv =====
module esa_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  esa_pkg::job_t    job_i,
  output logic             job_ready_o,
  input  esa_pkg::clr_t    clr_i,
  input  esa_pkg::cfg_t    cfg_i,
  output logic             back_idle_o,
  output logic             empty_o,
  input  logic             pop_i,
  output esa_pkg::result_t result_o
);
  import esa_pkg::*;

  logic                  e_valid_q;
  job_t                  e_job_q;
  logic [ECNT_W-1:0]     edge_cnt_q, edge_eff;

  logic                  wr_valid_q;
  logic [NODE_IDX_W-1:0] wr_addr_q;
  fill_t                 wr_data_q;

  fill_t                 rdata, cur, ram_wdata;
  logic                  ram_we;
  logic [NODE_IDX_W-1:0] ram_waddr;

  logic [CNT_W-1:0]      cnt;
  status_e               status;
  logic                  ok, e_fire, load;
  result_t               res;

  result_t               o_mem_q [2];
  logic                  o_wr_q, o_rd_q;
  logic [1:0]            o_cnt_q;
  logic                  o_full, o_pop;

  assign o_full  = (o_cnt_q == 2'd2);
  assign empty_o = (o_cnt_q == 2'd0);
  assign o_pop   = pop_i && !empty_o;
  assign result_o = o_mem_q[o_rd_q];

  assign e_fire      = e_valid_q && !o_full;
  assign job_ready_o = !e_valid_q || e_fire;
  assign load        = job_valid_i && job_ready_o;
  assign back_idle_o = !e_valid_q;

  esa_ram #(
    .WIDTH (FILL_W),
    .DEPTH (MAX_NODES)
  ) u_fill_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (load),
    .raddr_i (job_i.center[NODE_IDX_W-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    cur      = (wr_valid_q && (wr_addr_q == e_job_q.center[NODE_IDX_W-1:0]))
               ? wr_data_q : rdata;
    cnt      = (cur.tag == e_job_q.epoch) ? cur.count : '0;
    edge_eff = e_job_q.first ? '0 : edge_cnt_q;

    if (e_job_q.range_bad) begin
      status = STATUS_RANGE;
    end else if (edge_eff >= ECNT_W'(MAX_EDGES)) begin
      status = STATUS_EDGES;
    end else if (cnt >= cfg_i.slot_lim) begin
      status = STATUS_FULL;
    end else begin
      status = STATUS_OK;
    end
    ok = (status == STATUS_OK);

    res.status = status;
    if (ok) begin
      res.edge_number   = edge_eff[EDGE_W-1:0];
      res.slot          = cnt[SLOT_W-1:0];
      res.table_address = e_job_q.base + ADDR_W'(cnt);
    end else begin
      res.edge_number   = '0;
      res.slot          = '0;
      res.table_address = '0;
    end

    ram_we = clr_i.active || (e_fire && ok);
    if (clr_i.active) begin
      ram_waddr       = clr_i.addr;
      ram_wdata.tag   = EPOCH_LAST;
      ram_wdata.count = '0;
    end else begin
      ram_waddr       = e_job_q.center[NODE_IDX_W-1:0];
      ram_wdata.tag   = e_job_q.epoch;
      ram_wdata.count = cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_valid_q  <= 1'b0;
      edge_cnt_q <= '0;
      wr_valid_q <= 1'b0;
    end else begin
      if (load) begin
        e_valid_q <= 1'b1;
      end else if (e_fire) begin
        e_valid_q <= 1'b0;
      end
      if (e_fire) begin
        edge_cnt_q <= ok ? edge_eff + ECNT_W'(1) : edge_eff;
      end
      if (clr_i.active) begin
        wr_valid_q <= 1'b0;
      end else if (e_fire && ok) begin
        wr_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      e_job_q <= job_i;
    end
    if (ram_we) begin
      wr_addr_q <= ram_waddr;
      wr_data_q <= ram_wdata;
    end
    if (e_fire) begin
      o_mem_q[o_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_wr_q  <= 1'b0;
      o_rd_q  <= 1'b0;
      o_cnt_q <= 2'd0;
    end else begin
      if (e_fire) begin
        o_wr_q <= ~o_wr_q;
      end
      if (o_pop) begin
        o_rd_q <= ~o_rd_q;
      end
      case ({e_fire, o_pop})
        2'b10:   o_cnt_q <= o_cnt_q + 2'd1;
        2'b01:   o_cnt_q <= o_cnt_q - 2'd1;
        default: o_cnt_q <= o_cnt_q;
      endcase
    end
  end

endmodule

// ===== sv/edge_slot_assigner.sv =====
// Edge slot assigner: each accepted request names the center node of one edge
// and returns its running edge number, the node's next free slot and the flat
// padded-table address center*slots+slot, or a reject status that leaves all
// counters unchanged. One edge per cycle is sustained while results are popped;
// a result passes through the front job queue and the back stage register
// into the output queue, the pace being set by the single fill-counter
// read-modify-write per edge in the back stage, which forwards its most recent
// write. Counters are cleared per batch by an epoch tag in each counter entry,
// so a first_edge costs nothing, except that every 256th batch start holds full
// high until in-flight edges finish and then for a clearing pass over all 1024
// counter entries; the same pass runs after reset, and once more at the first
// batch start when edges were taken after reset before any first_edge.
// Configuration writes are always taken and must only be issued while idle.
module edge_slot_assigner (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  logic [esa_pkg::CENTER_W-1:0]   center_i,
  input  logic                           first_edge_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [esa_pkg::EDGE_W-1:0]     edge_number_o,
  output logic [esa_pkg::SLOT_W-1:0]     slot_o,
  output logic [esa_pkg::ADDR_W-1:0]     table_address_o,
  output logic [1:0]                     status_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  esa_pkg::cfg_idx_e              cfg_index_i,
  input  logic [esa_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import esa_pkg::*;

  logic [NODES_W-1:0] nodes_q;
  logic [SLOTS_W-1:0] slots_q;
  cfg_t               cfg;

  logic    job_valid, job_ready, back_idle;
  job_t    job;
  clr_t    clr;
  result_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q <= NODES_W'(1024);
      slots_q <= SLOTS_W'(64);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_NODES: nodes_q <= cfg_data_i[NODES_W-1:0];
        CFG_SLOTS: slots_q <= cfg_data_i[SLOTS_W-1:0];
        default:   nodes_q <= nodes_q;
      endcase
    end
  end

  always_comb begin
    cfg.node_lim = (nodes_q > NODES_W'(MAX_NODES)) ? NODES_W'(MAX_NODES) : nodes_q;
    cfg.slot_lim = (slots_q > SLOTS_W'(SLOT_CAP)) ? SLOTS_W'(SLOT_CAP) : slots_q;
  end

  esa_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .center_i     (center_i),
    .first_edge_i (first_edge_i),
    .cfg_i        (cfg),
    .back_idle_i  (back_idle),
    .job_valid_o  (job_valid),
    .job_o        (job),
    .job_ready_i  (job_ready),
    .clr_o        (clr)
  );

  esa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .job_ready_o (job_ready),
    .clr_i       (clr),
    .cfg_i       (cfg),
    .back_idle_o (back_idle),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (res)
  );

  assign edge_number_o   = res.edge_number;
  assign slot_o          = res.slot;
  assign table_address_o = res.table_address;
  assign status_o        = res.status;

endmodule

// ===== sv/esa_checker.sv =====
`include "edge_slot_assigner_assert.svh"

module esa_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [esa_pkg::EDGE_W-1:0]   edge_number_o,
  input logic [esa_pkg::SLOT_W-1:0]   slot_o,
  input logic [esa_pkg::ADDR_W-1:0]   table_address_o,
  input logic [1:0]                   status_o
);
  import esa_pkg::*;

  logic [3:0] pend_q;
  logic       in_acc, out_acc;
  logic       rej_zero;
  logic [EDGE_W+SLOT_W+ADDR_W+1:0] res_bits;

  assign in_acc   = push && !full;
  assign out_acc  = pop && !empty;
  assign rej_zero = (edge_number_o == '0) && (slot_o == '0) && (table_address_o == '0);
  assign res_bits = {edge_number_o, slot_o, table_address_o, status_o};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 4'd0;
    end else begin
      case ({in_acc, out_acc})
        2'b10:   pend_q <= pend_q + 4'd1;
        2'b01:   pend_q <= pend_q - 4'd1;
        default: pend_q <= pend_q;
      endcase
    end
  end

  `ESA_ASSERT_IMP(a_result_has_request, !empty, pend_q != 4'd0)
  `ESA_ASSERT_IMP(a_pending_bound, 1'b1, pend_q <= 4'd5)
  `ESA_ASSERT_IMP(a_reject_zero, !empty && (status_o != STATUS_OK), rej_zero)
  `ESA_ASSERT_NEXT(a_result_holds, !empty && !pop, !empty && $stable(res_bits))

endmodule

bind edge_slot_assigner esa_checker u_esa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .edge_number_o   (edge_number_o),
  .slot_o          (slot_o),
  .table_address_o (table_address_o),
  .status_o        (status_o)
);

// ===== verif/edge_slot_checker.sv =====
`timescale 1ns / 1ps

module edge_slot_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  input  logic                           full,
  input  logic [esa_pkg::CENTER_W-1:0]   center_i,
  input  logic                           first_edge_i,
  input  logic                           empty,
  input  logic                           pop,
  input  logic [esa_pkg::EDGE_W-1:0]     edge_number_o,
  input  logic [esa_pkg::SLOT_W-1:0]     slot_o,
  input  logic [esa_pkg::ADDR_W-1:0]     table_address_o,
  input  logic [1:0]                     status_o,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_o,
  input  esa_pkg::cfg_idx_e              cfg_index_i,
  input  logic [esa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned                    mismatches_o,
  output int unsigned                    pending_o
);
  import esa_pkg::*;

  logic [CNT_W-1:0]   fill_cnt [MAX_NODES];
  logic [ECNT_W-1:0]  batch_edges;
  logic [NODES_W-1:0] node_lim;
  logic [SLOTS_W-1:0] slot_lim;
  result_t            slot_grants_q [$];
  int unsigned        mismatch_count = 0;

  function automatic result_t assign_slot(logic [CENTER_W-1:0] c, logic f);
    result_t     r;
    int unsigned nodes;
    int unsigned slots;
    r = '0;
    if (f) begin
      foreach (fill_cnt[n]) fill_cnt[n] = '0;
      batch_edges = '0;
    end
    nodes = (node_lim > MAX_NODES) ? MAX_NODES : node_lim;
    slots = (slot_lim > SLOT_CAP) ? SLOT_CAP : slot_lim;
    if (c >= nodes) begin
      r.status = STATUS_RANGE;
    end else if (batch_edges >= MAX_EDGES) begin
      r.status = STATUS_EDGES;
    end else if (fill_cnt[c] >= slots) begin
      r.status = STATUS_FULL;
    end else begin
      r.status        = STATUS_OK;
      r.edge_number   = batch_edges[EDGE_W-1:0];
      r.slot          = fill_cnt[c][SLOT_W-1:0];
      r.table_address = ADDR_W'(c * slots + fill_cnt[c]);
      fill_cnt[c]     = fill_cnt[c] + 1'b1;
      batch_edges     = batch_edges + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      foreach (fill_cnt[n]) fill_cnt[n] = '0;
      batch_edges = '0;
      node_lim    = NODES_W'(MAX_NODES);
      slot_lim    = SLOTS_W'(MAX_SLOTS);
      slot_grants_q.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_NODES: node_lim = cfg_data_i[NODES_W-1:0];
          CFG_SLOTS: slot_lim = cfg_data_i[SLOTS_W-1:0];
          default: ;
        endcase
      end
      if (pop && !empty) begin
        if (slot_grants_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: result with no request pending: edge %0d slot %0d addr %0d st %0d",
                     $realtime, edge_number_o, slot_o, table_address_o, status_o);
        end else begin
          want = slot_grants_q.pop_front();
          if (want.edge_number !== edge_number_o || want.slot !== slot_o ||
              want.table_address !== table_address_o || want.status !== status_o) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: expected edge %0d slot %0d addr %0d st %0d, got %0d %0d %0d %0d",
                       $realtime, want.edge_number, want.slot, want.table_address,
                       want.status, edge_number_o, slot_o, table_address_o, status_o);
          end
        end
      end
      if (push && !full)
        slot_grants_q.push_back(assign_slot(center_i, first_edge_i));
    end
    mismatches_o <= mismatch_count;
    pending_o    <= slot_grants_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import esa_pkg::*;

  localparam int unsigned IDLE_LIMIT  = 5000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_WAIT  = 10;

  logic                  clk_i        = 1'b0;
  logic                  rst_ni       = 1'b0;
  logic                  push         = 1'b0;
  logic                  full;
  logic [CENTER_W-1:0]   center_i     = '0;
  logic                  first_edge_i = 1'b0;
  logic                  empty;
  logic                  pop          = 1'b0;
  logic [EDGE_W-1:0]     edge_number_o;
  logic [SLOT_W-1:0]     slot_o;
  logic [ADDR_W-1:0]     table_address_o;
  logic [1:0]            status_o;
  logic                  cfg_valid_i  = 1'b0;
  logic                  cfg_ready_o;
  cfg_idx_e              cfg_index_i  = CFG_NODES;
  logic [CFG_DATA_W-1:0] cfg_data_i   = '0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned tx_gap_max = 14;
  int unsigned rx_gap_max = 14;
  int unsigned rx_wait    = 0;
  int unsigned idle_cycles = 0;
  int unsigned cur_nodes  = MAX_NODES;
  logic        rx_hold    = 1'b0;
  bit          hold_go    = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  edge_slot_assigner dut (
    .clk_i, .rst_ni, .push, .full, .center_i, .first_edge_i, .empty, .pop,
    .edge_number_o, .slot_o, .table_address_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  edge_slot_checker u_slot_check (
    .clk_i, .rst_ni, .push, .full, .center_i, .first_edge_i, .empty, .pop,
    .edge_number_o, .slot_o, .table_address_o, .status_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  // receiver: random wait after each accepted result, long hold-off once
  always @(posedge clk_i or negedge rst_ni) begin
    int unsigned w;
    if (!rst_ni) begin
      pop     <= 1'b0;
      rx_wait <= 0;
    end else if (pop && !empty) begin
      w = $urandom_range(0, rx_gap_max);
      rx_wait <= w;
      pop     <= (w == 0) && !rx_hold;
    end else if (rx_wait > 1) begin
      rx_wait <= rx_wait - 1;
      pop     <= 1'b0;
    end else begin
      rx_wait <= 0;
      pop     <= !rx_hold;
    end
  end

  initial begin
    wait (hold_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  task automatic send_edge(input logic [CENTER_W-1:0] c, input logic f);
    int unsigned gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push         <= 1'b1;
    center_i     <= c;
    first_edge_i <= f;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  task automatic drain;
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == CFG_NODES)
      cur_nodes = (d > MAX_NODES) ? MAX_NODES : d;
  endtask

  function automatic logic [CENTER_W-1:0] pick_center(input int unsigned hot);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (cur_nodes == 0 || roll == 0)
      return CENTER_W'($urandom_range(0, MAX_NODES - 1));
    if (roll < 6)
      return CENTER_W'($urandom_range(0, ((cur_nodes < hot) ? cur_nodes : hot) - 1));
    return CENTER_W'($urandom_range(0, cur_nodes - 1));
  endfunction

  task automatic run_batch(input int unsigned count, input int unsigned hot,
                           input int unsigned first_odds);
    for (int unsigned i = 0; i < count; i++)
      send_edge(pick_center(hot), $urandom_range(0, first_odds - 1) == 0);
  endtask

  initial begin
    int unsigned tx_pick [5];
    int unsigned rx_pick [5];
    int unsigned hot;
    tx_pick = '{14, 0, 0, 14, 14};
    rx_pick = '{14, 14, 0, 0, 14};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: default limits, then the extremes of both registers
    send_edge(10'd0, 1'b1);
    send_edge(10'd1023, 1'b0);
    send_edge(10'd0, 1'b0);
    send_edge(10'd1023, 1'b0);
    send_edge(10'd512, 1'b1);
    send_edge(10'd512, 1'b0);
    drain();
    write_reg(CFG_NODES, 11'd1);
    write_reg(CFG_SLOTS, 11'd1);
    send_edge(10'd0, 1'b1);
    send_edge(10'd0, 1'b0);
    send_edge(10'd1, 1'b0);
    send_edge(10'd1023, 1'b0);
    drain();
    write_reg(CFG_SLOTS, 11'd2);
    send_edge(10'd0, 1'b0);
    drain();
    write_reg(CFG_NODES, 11'd0);
    send_edge(10'd0, 1'b0);
    drain();
    write_reg(CFG_NODES, 11'd2047);
    write_reg(CFG_SLOTS, 11'd127);
    send_edge(10'd1023, 1'b1);
    send_edge(10'd1023, 1'b0);
    drain();
    write_reg(CFG_SLOTS, 11'd0);
    send_edge(10'd5, 1'b0);
    send_edge(10'd1023, 1'b0);
    drain();
    write_reg(CFG_SLOTS, 11'h7C0);
    send_edge(10'd7, 1'b0);
    drain();
    write_reg(CFG_NODES, 11'd1024);
    send_edge(10'd1023, 1'b0);
    drain();

    // fill every slot of the last node back to back, then run it past full
    tx_gap_max = 0;
    rx_gap_max <= 0;
    write_reg(CFG_SLOTS, 11'd64);
    for (int unsigned s = 0; s < MAX_SLOTS + 2; s++)
      send_edge(10'd1023, s == 0);
    send_edge(10'd5, 1'b0);
    drain();
    write_reg(CFG_NODES, 11'd512);
    send_edge(10'd700, 1'b0);
    send_edge(10'd5, 1'b0);
    send_edge(10'd5, 1'b1);
    drain();

    for (int unsigned k = 0; k < 5; k++) begin
      case (k)
        0: begin
          write_reg(CFG_NODES, 11'd1);
          write_reg(CFG_SLOTS, 11'd1);
          hot = 1;
        end
        1: begin
          write_reg(CFG_NODES, 11'd2047);
          write_reg(CFG_SLOTS, 11'd127);
          hot = 4;
        end
        2: begin
          write_reg(CFG_NODES, 11'd1024);
          write_reg(CFG_SLOTS, 11'd64);
          hot = 1;
        end
        3: begin
          write_reg(CFG_NODES, CFG_DATA_W'($urandom_range(2, 40)));
          write_reg(CFG_SLOTS, CFG_DATA_W'($urandom_range(1, 6)));
          hot = 3;
        end
        default: begin
          write_reg(CFG_NODES, CFG_DATA_W'($urandom_range(0, 2047)));
          write_reg(CFG_SLOTS, CFG_DATA_W'($urandom_range(0, 2047)));
          hot = 8;
        end
      endcase
      tx_gap_max = tx_pick[k];
      rx_gap_max <= rx_pick[k];
      if (k == 2)
        hold_go = 1'b1;
      run_batch(50, hot, 12);
      drain();
    end

    // many short batches, enough starts to wrap the batch tag
    write_reg(CFG_NODES, 11'd16);
    write_reg(CFG_SLOTS, 11'd4);
    for (int unsigned i = 0; i < 6; i++) begin
      tx_gap_max = $urandom_range(0, 1) * 14;
      rx_gap_max <= $urandom_range(0, 1) * 14;
      for (int unsigned j = 0; j < 50; j++)
        send_edge(pick_center(4), $urandom_range(0, 15) != 0);
    end

    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (mismatches == 0 && pending == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule

// ===== edge_slot_assigner.f =====
+incdir+sv
sv/esa_pkg.sv
sv/esa_ram.sv
sv/esa_front.sv
sv/esa_back.sv
sv/edge_slot_assigner.sv
sv/esa_checker.sv
verif/edge_slot_checker.sv
verif/testbench.sv
